>>> hdl/htfd_pkg.sv
// Shared types, constants and helper functions for the humidity/temperature
// frame decoder. No dependencies; imported by humidity_temp_frame_decoder and its testbench.
`default_nettype none

package htfd_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 9;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COMP_ENABLE = 1'b0,
		CFG_COMP_COEF   = 1'b1
	} cfg_index_t;

	localparam logic              COMP_EN_RESET   = 1'b1;
	localparam logic signed [8:0] COMP_COEF_RESET = -9'sd38;

	// Command codes carried in the request.
	typedef enum logic [2:0] {
		CMD_TEMP       = 3'd0,
		CMD_TEMP_NOCRC = 3'd1,
		CMD_HUM        = 3'd2,
		CMD_HUM_COMP   = 3'd3,
		CMD_DEV_ID     = 3'd4
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_CRC    = 2'd1,
		STATUS_CHIP   = 2'd2,
		STATUS_NOTEMP = 2'd3
	} status_t;

	// Conversion constants: value = (SCALE * raw >> 16) - OFFSET, in hundredths.
	localparam logic [14:0]        TEMP_SCALE  = 15'd17572;
	localparam logic [14:0]        HUM_SCALE   = 15'd12500;
	localparam logic signed [15:0] TEMP_OFFSET = 16'sd4685;
	localparam logic signed [15:0] HUM_OFFSET  = 16'sd600;
	localparam logic signed [15:0] HUM_MAX     = 16'sd10000;
	localparam logic signed [15:0] COMP_REF_T  = 16'sd2500;
	localparam logic signed [14:0] COMP_T_MAX  = 15'sd8000;
	localparam logic [7:0]         CRC_POLY    = 8'h31;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] msb_byte;
		logic [7:0] lsb_byte;
		logic [7:0] crc_byte;
	} frame_t;

	typedef struct packed {
		logic signed [14:0] value;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic        known;
		logic [14:0] model;
	} chip_info_t;

	// One byte through the CRC-8 shift register, MSB first.
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] crc;
		crc = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (crc[7]) begin
				crc = {crc[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				crc = {crc[6:0], 1'b0};
			end
		end
		return crc;
	endfunction

	// Chip-ID byte to device model number.
	function automatic chip_info_t chip_lookup(input logic [7:0] id);
		chip_info_t info;
		info.known = 1'b1;
		case (id)
			8'h32:        info.model = 15'd21;
			8'h15:        info.model = 15'd7021;
			8'h14:        info.model = 15'd7020;
			8'h0D:        info.model = 15'd7013;
			8'h06:        info.model = 15'd7006;
			8'h00, 8'hFF: info.model = 15'd7000;
			default: begin
				info.known = 1'b0;
				info.model = '0;
			end
		endcase
		return info;
	endfunction

endpackage

`default_nettype wire

>>> hdl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature frame decoder: input register, single
// pass conversion logic, result register. Depends on htfd_pkg.
//
// Usage: each request on the frame channel carries one sensor read frame (a
// command, two data bytes and the received CRC byte). A request is taken at a
// rising edge where frame_valid is high and frame_stall is low. Every request
// yields exactly one result on the result channel, which is taken at an edge
// where result_valid is high and result_stall is low.
// A taken request is held in the input register and moves into the result
// register when that one is empty or being taken. Throughput is one request
// per cycle while result_stall is low: the conversion (one shared 15x16
// multiplier for the raw scaling and one 16x9 multiplier for the compensation
// term, in parallel) is done in a single pass between the two registers.
// The stored temperature and its valid flag are updated in the same edge that
// moves a request into the result register, so the next request already sees
// them. When the receiver stalls, the result register holds its value and the
// input register still takes one more request; frame_stall rises only when
// both are full and the result is stalled.
// Reset (arst_n low) empties both registers, clears the stored temperature,
// and sets compensation enabled with a coefficient of -38 (Q8).
// Configuration writes through cfg_we/cfg_index/cfg_data take effect at once.
`default_nettype none

module humidity_temp_frame_decoder
	import htfd_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   frame_valid,
	output logic                        frame_stall,
	input  wire frame_t                 frame,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output result_t                     result,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// Input register stage.
	logic   frame_valid_s1;
	frame_t frame_s1;

	// Result register.
	logic    result_valid_q;
	result_t result_q;

	// Configuration and sensor state.
	logic              comp_en_q;
	logic signed [8:0] comp_coef_q;
	logic signed [14:0] last_temp_q;
	logic              temp_valid_q;

	logic advance;
	logic frame_accept;

	// Conversion datapath.
	cmd_t               cmd_e;
	logic [15:0]        raw_m;
	logic [7:0]         crc_calc;
	logic               crc_ok;
	logic [14:0]        scale;
	logic [30:0]        prod;
	logic [14:0]        conv;
	logic signed [15:0] temp_c;
	logic signed [15:0] hum_raw;
	logic signed [15:0] hum_clamp;
	logic signed [15:0] temp_diff;
	logic signed [24:0] comp_prod;
	logic signed [16:0] comp_term;
	logic signed [16:0] hum_comp;
	logic               temp_in_range;
	chip_info_t         chip;

	result_t            nxt_result;
	logic signed [14:0] nxt_temp;
	logic               nxt_temp_valid;

	// The input register moves on whenever the result register is empty or
	// its contents are being taken this cycle.
	assign advance      = frame_valid_s1 && (!result_valid_q || !result_stall);
	assign frame_stall  = frame_valid_s1 && result_valid_q && result_stall;
	assign frame_accept = frame_valid && !frame_stall;

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (frame_accept) begin
			frame_valid_s1 <= 1'b1;
		end else if (advance) begin
			frame_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_accept) begin
			frame_s1 <= frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= nxt_result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_en_q   <= COMP_EN_RESET;
			comp_coef_q <= COMP_COEF_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_COMP_ENABLE: comp_en_q   <= cfg_data[0];
				CFG_COMP_COEF:   comp_coef_q <= $signed(cfg_data[8:0]);
				default: ;
			endcase
		end
	end

	// The temperature is kept already converted, in hundredths of a degree.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_temp_q  <= '0;
			temp_valid_q <= 1'b0;
		end else if (advance) begin
			last_temp_q  <= nxt_temp;
			temp_valid_q <= nxt_temp_valid;
		end
	end

	// Shared scaling: the two status bits of the raw word are dropped first.
	always_comb begin
		cmd_e    = cmd_t'(frame_s1.cmd);
		raw_m    = {frame_s1.msb_byte, frame_s1.lsb_byte[7:2], 2'b00};
		crc_calc = crc8_byte(crc8_byte(8'h00, frame_s1.msb_byte), frame_s1.lsb_byte);
		crc_ok   = (crc_calc == frame_s1.crc_byte);

		if (cmd_e == CMD_TEMP || cmd_e == CMD_TEMP_NOCRC) begin
			scale = TEMP_SCALE;
		end else begin
			scale = HUM_SCALE;
		end
		prod    = 31'(scale) * 31'(raw_m);
		conv    = prod[30:16];
		temp_c  = $signed({1'b0, conv}) - TEMP_OFFSET;
		hum_raw = $signed({1'b0, conv}) - HUM_OFFSET;

		if (hum_raw < 0) begin
			hum_clamp = '0;
		end else if (hum_raw > HUM_MAX) begin
			hum_clamp = HUM_MAX;
		end else begin
			hum_clamp = hum_raw;
		end

		// Compensation term, floor((2500 - T) * coef / 256), from the stored T.
		temp_diff     = COMP_REF_T - 16'(last_temp_q);
		comp_prod     = 25'(temp_diff) * 25'(comp_coef_q);
		comp_term     = comp_prod[24:8];
		hum_comp      = 17'(hum_clamp) + comp_term;
		temp_in_range = (last_temp_q >= 15'sd0) && (last_temp_q <= COMP_T_MAX);

		chip = chip_lookup(frame_s1.msb_byte);
	end

	// Result and state selection per command.
	always_comb begin
		nxt_result.value  = '0;
		nxt_result.status = STATUS_OK;
		nxt_temp          = last_temp_q;
		nxt_temp_valid    = temp_valid_q;
		case (cmd_e)
			CMD_TEMP, CMD_TEMP_NOCRC: begin
				if (cmd_e == CMD_TEMP && !crc_ok) begin
					nxt_result.status = STATUS_CRC;
					nxt_temp_valid    = 1'b0;
				end else begin
					nxt_result.value = temp_c[14:0];
					nxt_temp         = temp_c[14:0];
					nxt_temp_valid   = 1'b1;
				end
			end
			CMD_HUM, CMD_HUM_COMP: begin
				if (cmd_e == CMD_HUM_COMP && !temp_valid_q) begin
					nxt_result.status = STATUS_NOTEMP;
				end else if (!crc_ok) begin
					nxt_result.status = STATUS_CRC;
				end else if (cmd_e == CMD_HUM_COMP && comp_en_q && temp_in_range) begin
					nxt_result.value = hum_comp[14:0];
				end else begin
					nxt_result.value = hum_clamp[14:0];
				end
			end
			CMD_DEV_ID: begin
				if (!crc_ok) begin
					nxt_result.status = STATUS_CRC;
				end else if (!chip.known) begin
					nxt_result.status = STATUS_CHIP;
				end else begin
					nxt_result.value = chip.model;
				end
			end
			default: ;
		endcase
	end

	// An error result never carries a value.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && (result_q.status != STATUS_OK) |-> (result_q.value == 15'sd0))
		else $error("error result with nonzero value");

	// A failed temperature read drops the stored temperature.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_e == CMD_TEMP) && !crc_ok |=> !temp_valid_q)
		else $error("stored temperature still valid after failed read");

	// Compensated humidity without a stored temperature reports it.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_e == CMD_HUM_COMP) && !temp_valid_q
		|=> result_valid_q && (result_q.status == STATUS_NOTEMP))
		else $error("missing temperature not reported");

	// Plain humidity stays within its clamp.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_e == CMD_HUM) && crc_ok
		|=> (result_q.value >= 15'sd0) && (result_q.value <= 15'sd10000))
		else $error("plain humidity outside 0..10000");

endmodule

`default_nettype wire

>>> tb/humidity_temp_frame_decoder_tb.sv
// Self-checking testbench for humidity_temp_frame_decoder: a directed table followed by
// random sensor frames under several compensation settings, scored by table or predictor.
// Depends on htfd_pkg and the humidity_temp_frame_decoder RTL.
`default_nettype none

module humidity_temp_frame_decoder_tb;
	import htfd_pkg::*;

	// Command codes that the decoder ignores; they still return a zero result.
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	// Masked raw words where the converted temperature crosses 0 and 8000 hundredths.
	// The compensation window is closed on both ends, so frames are steered near both.
	localparam logic [15:0] RAW_T_ZERO = 16'd17476;
	localparam logic [15:0] RAW_T_8000 = 16'd47312;

	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_LIMIT = 200;

	// One row of the directed table. When typed is set, the expected result is the one
	// written in the row; otherwise it comes from the predictor.
	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] msb;
		logic [7:0] lsb;
		logic       crc_bad;
		logic       typed;
		result_t    want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic frame_valid = 1'b0;
	logic frame_stall;
	frame_t frame = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the configuration registers, starting at their reset values.
	logic comp_en_mirror = COMP_EN_RESET;
	logic signed [8:0] comp_coef_mirror = COMP_COEF_RESET;

	// Predictor copy of the stored temperature: the 14 useful bits and their valid flag.
	logic [13:0] temp_code_held = '0;
	logic temp_held_ok = 1'b0;

	result_t expected_results[$];
	dir_row_t directed_rows[$];
	int mismatches = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit random_started = 1'b0;
	bit hold_off_done = 1'b0;

	always #1 clk = ~clk;

	humidity_temp_frame_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_stall(frame_stall),
		.frame(frame),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// CRC-8 with polynomial 0x31 and a zero start value, fed one bit at a time, MSB first.
	// Feeding the sixteen bits serially gives the same result as the byte-wise form.
	function automatic logic [7:0] frame_crc(input logic [15:0] data);
		logic [7:0] crc;
		logic feedback;
		crc = 8'h00;
		for (int i = 15; i >= 0; i--) begin
			feedback = crc[7] ^ data[i];
			crc = {crc[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
		end
		return crc;
	endfunction

	// Temperature in hundredths of a degree from the 14 useful bits of a raw word.
	function automatic int temp_hundredths(input logic [13:0] code);
		int scaled;
		scaled = 17572 * int'({code, 2'b00});
		return (scaled >>> 16) - 4685;
	endfunction

	// Computes the result of one frame and updates the stored temperature as the
	// decoder does. The configuration mirror is only read here.
	function automatic result_t decode_frame(input frame_t f);
		logic [15:0] raw;
		logic crc_good;
		int hum;
		int t;
		result_t r;
		raw = {f.msb_byte, f.lsb_byte};
		crc_good = (frame_crc(raw) == f.crc_byte);
		r.value = '0;
		r.status = STATUS_OK;
		case (f.cmd)
			CMD_TEMP, CMD_TEMP_NOCRC: begin
				// Only the plain temperature read is CRC checked; a failed one also
				// forgets the stored temperature.
				if (f.cmd == CMD_TEMP && !crc_good) begin
					r.status = STATUS_CRC;
					temp_held_ok = 1'b0;
				end else begin
					t = temp_hundredths(raw[15:2]);
					r.value = t[14:0];
					temp_code_held = raw[15:2];
					temp_held_ok = 1'b1;
				end
			end
			CMD_HUM, CMD_HUM_COMP: begin
				// A missing temperature wins over a bad CRC on a compensated read.
				if (f.cmd == CMD_HUM_COMP && !temp_held_ok) begin
					r.status = STATUS_NOTEMP;
				end else if (!crc_good) begin
					r.status = STATUS_CRC;
				end else begin
					hum = ((12500 * int'({raw[15:2], 2'b00})) >>> 16) - 600;
					if (hum < 0) begin
						hum = 0;
					end else if (hum > 10000) begin
						hum = 10000;
					end
					if (f.cmd == CMD_HUM_COMP && comp_en_mirror) begin
						t = temp_hundredths(temp_code_held);
						// The correction is added after the clamp and floors toward
						// minus infinity, which an arithmetic shift gives directly.
						if (t >= 0 && t <= 8000) begin
							hum = hum + (((2500 - t) * int'(comp_coef_mirror)) >>> 8);
						end
					end
					r.value = hum[14:0];
				end
			end
			CMD_DEV_ID: begin
				if (!crc_good) begin
					r.status = STATUS_CRC;
				end else begin
					case (f.msb_byte)
						8'h32: r.value = 15'sd21;
						8'h15: r.value = 15'sd7021;
						8'h14: r.value = 15'sd7020;
						8'h0D: r.value = 15'sd7013;
						8'h06: r.value = 15'sd7006;
						8'h00, 8'hFF: r.value = 15'sd7000;
						default: r.status = STATUS_CHIP;
					endcase
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Random frame, mostly well formed. Temperature frames are sometimes steered to
	// the edges of the compensation window, and device-ID frames mostly carry a
	// known chip ID so that the model table is exercised.
	function automatic frame_t random_frame();
		frame_t f;
		int pick;
		logic [15:0] raw;
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			f.cmd = CMD_TEMP;
		end else if (pick < 30) begin
			f.cmd = CMD_TEMP_NOCRC;
		end else if (pick < 48) begin
			f.cmd = CMD_HUM;
		end else if (pick < 85) begin
			f.cmd = CMD_HUM_COMP;
		end else if (pick < 95) begin
			f.cmd = CMD_DEV_ID;
		end else begin
			f.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		raw = 16'($urandom);
		if ((f.cmd == CMD_TEMP || f.cmd == CMD_TEMP_NOCRC) && $urandom_range(0, 9) < 3) begin
			raw = ($urandom_range(0, 1) ? RAW_T_ZERO : RAW_T_8000)
				+ 16'($urandom_range(0, 16)) - 16'd8;
		end
		if (f.cmd == CMD_DEV_ID && $urandom_range(0, 9) < 7) begin
			case ($urandom_range(0, 6))
				0: raw[15:8] = 8'h32;
				1: raw[15:8] = 8'h15;
				2: raw[15:8] = 8'h14;
				3: raw[15:8] = 8'h0D;
				4: raw[15:8] = 8'h06;
				5: raw[15:8] = 8'h00;
				default: raw[15:8] = 8'hFF;
			endcase
		end
		f.msb_byte = raw[15:8];
		f.lsb_byte = raw[7:0];
		f.crc_byte = frame_crc(raw);
		if ($urandom_range(0, 99) < 12) begin
			f.crc_byte = f.crc_byte ^ 8'($urandom_range(1, 255));
		end
		return f;
	endfunction

	task automatic add_row(input logic [2:0] cmd, input logic [7:0] msb, input logic [7:0] lsb,
			input logic crc_bad, input logic typed, input logic signed [14:0] value,
			input status_t status);
		dir_row_t row;
		row.cmd = cmd;
		row.msb = msb;
		row.lsb = lsb;
		row.crc_bad = crc_bad;
		row.typed = typed;
		row.want.value = value;
		row.want.status = status;
		directed_rows.push_back(row);
	endtask

	// Offers one request and holds it until it is taken, then records the result it
	// should produce. Called right after a rising edge; valid stays high on return so
	// that a following request goes out back to back.
	task automatic send_frame(input frame_t f, input logic typed, input result_t typed_res);
		result_t predicted;
		frame <= f;
		frame_valid <= 1'b1;
		@(posedge clk);
		while (frame_stall) begin
			@(posedge clk);
		end
		predicted = decode_frame(f);
		expected_results.push_back(typed ? typed_res : predicted);
	endtask

	// Sender pacing: bursts of random length, and after most bursts a random gap.
	task automatic sender_idle();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			if ($urandom_range(0, 3) != 0) begin
				frame_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	// Stops offering and waits until every expected result has come out. Every
	// request makes a result, so an empty queue means the decoder is idle; a
	// trailing wait then covers the result register.
	task automatic drain();
		int waited;
		waited = 0;
		frame_valid <= 1'b0;
		while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (2) @(posedge clk);
	endtask

	// Writes both registers on consecutive edges; the write enable is dropped once.
	task automatic apply_settings(input logic en, input logic signed [8:0] coef);
		cfg_we <= 1'b1;
		cfg_index <= CFG_COMP_ENABLE;
		cfg_data <= {{(CFG_DATA_W-1){1'b0}}, en};
		@(posedge clk);
		cfg_index <= CFG_COMP_COEF;
		cfg_data <= coef;
		@(posedge clk);
		cfg_we <= 1'b0;
		comp_en_mirror = en;
		comp_coef_mirror = coef;
	endtask

	task automatic run_phase(input logic en, input logic signed [8:0] coef, input int count);
		drain();
		apply_settings(en, coef);
		random_started = 1'b1;
		for (int n = 0; n < count; n++) begin
			send_frame(random_frame(), 1'b0, '0);
			sender_idle();
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Stimulus. The directed table runs under the reset configuration, so its first
	// rows also check that reset leaves no stored temperature behind.
	initial begin
		frame_t f;
		logic [15:0] raw;
		// Compensated read right after reset, then with a bad CRC: no temperature yet,
		// and that is reported before the CRC.
		add_row(CMD_HUM_COMP, 8'h00, 8'h00, 1'b0, 1'b1, 15'sd0, STATUS_NOTEMP);
		add_row(CMD_HUM_COMP, 8'h12, 8'h34, 1'b1, 1'b1, 15'sd0, STATUS_NOTEMP);
		add_row(CMD_TEMP, 8'h00, 8'h00, 1'b1, 1'b1, 15'sd0, STATUS_CRC);
		// The unchecked temperature read ignores its CRC; a zero word is the coldest value.
		add_row(CMD_TEMP_NOCRC, 8'h00, 8'h00, 1'b1, 1'b1, -15'sd4685, STATUS_OK);
		// Stored temperature below the window: plain humidity comes back.
		add_row(CMD_HUM_COMP, 8'h80, 8'h00, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		// Hottest word, with both status bits set, above the window.
		add_row(CMD_TEMP, 8'hFF, 8'hFF, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		add_row(CMD_HUM_COMP, 8'h70, 8'h00, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		// A temperature inside the window, then compensation at both clamp limits.
		add_row(CMD_TEMP, 8'h66, 8'h66, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		add_row(CMD_HUM_COMP, 8'hFF, 8'hFF, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		add_row(CMD_HUM_COMP, 8'h00, 8'h00, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		add_row(CMD_HUM, 8'h00, 8'h00, 1'b0, 1'b1, 15'sd0, STATUS_OK);
		add_row(CMD_HUM, 8'hFF, 8'hFF, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		add_row(CMD_HUM, 8'h12, 8'h34, 1'b1, 1'b1, 15'sd0, STATUS_CRC);
		add_row(CMD_TEMP, 8'h40, 8'h03, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		add_row(CMD_HUM_COMP, 8'h6A, 8'h3E, 1'b0, 1'b0, 15'sd0, STATUS_OK);
		// A failed temperature read forgets the stored value.
		add_row(CMD_TEMP, 8'h12, 8'h34, 1'b1, 1'b1, 15'sd0, STATUS_CRC);
		add_row(CMD_HUM_COMP, 8'h7C, 8'h80, 1'b0, 1'b1, 15'sd0, STATUS_NOTEMP);
		// Every known chip ID, an unknown one, and a bad CRC on a known one.
		add_row(CMD_DEV_ID, 8'h32, 8'h00, 1'b0, 1'b1, 15'sd21, STATUS_OK);
		add_row(CMD_DEV_ID, 8'h15, 8'hFF, 1'b0, 1'b1, 15'sd7021, STATUS_OK);
		add_row(CMD_DEV_ID, 8'h14, 8'h5A, 1'b0, 1'b1, 15'sd7020, STATUS_OK);
		add_row(CMD_DEV_ID, 8'h0D, 8'hA5, 1'b0, 1'b1, 15'sd7013, STATUS_OK);
		add_row(CMD_DEV_ID, 8'h06, 8'h01, 1'b0, 1'b1, 15'sd7006, STATUS_OK);
		add_row(CMD_DEV_ID, 8'h00, 8'h80, 1'b0, 1'b1, 15'sd7000, STATUS_OK);
		add_row(CMD_DEV_ID, 8'hFF, 8'h7F, 1'b0, 1'b1, 15'sd7000, STATUS_OK);
		add_row(CMD_DEV_ID, 8'h33, 8'h00, 1'b0, 1'b1, 15'sd0, STATUS_CHIP);
		add_row(CMD_DEV_ID, 8'h32, 8'h00, 1'b1, 1'b1, 15'sd0, STATUS_CRC);
		// Unused command codes give an empty result.
		add_row(CMD_UNUSED_LO, 8'h12, 8'h34, 1'b0, 1'b1, 15'sd0, STATUS_OK);
		add_row(CMD_UNUSED_HI, 8'hFF, 8'hFF, 1'b1, 1'b1, 15'sd0, STATUS_OK);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			raw = {directed_rows[i].msb, directed_rows[i].lsb};
			f.cmd = directed_rows[i].cmd;
			f.msb_byte = directed_rows[i].msb;
			f.lsb_byte = directed_rows[i].lsb;
			f.crc_byte = frame_crc(raw) ^ (directed_rows[i].crc_bad ? 8'h5A : 8'h00);
			send_frame(f, directed_rows[i].typed, directed_rows[i].want);
			sender_idle();
		end

		// Random phases, each under its own setting: the reset values written back,
		// compensation off, the coefficient at both extremes and at zero, and one
		// random setting.
		run_phase(1'b1, -9'sd38, 300);
		run_phase(1'b0, 9'sd100, 250);
		run_phase(1'b1, -9'sd256, 300);
		run_phase(1'b1, 9'sd255, 300);
		run_phase(1'b1, 9'sd0, 300);
		run_phase(1'($urandom_range(0, 1)), 9'($urandom), 300);

		drain();
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		end
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Receiver. Once the random part starts it holds off for a long stretch so that
	// both internal registers fill and the decoder stalls its requests. Otherwise it
	// moves through segments of random length: no stall, coin flips, a periodic
	// pattern, or mostly stalled.
	initial begin
		int mode;
		int seg_len;
		int period;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (random_started && !hold_off_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				seg_len = $urandom_range(1, 60);
				period = $urandom_range(2, 5);
				for (int k = 0; k < seg_len; k++) begin
					case (mode)
						0: result_stall <= 1'b0;
						1: result_stall <= 1'($urandom_range(0, 1));
						2: result_stall <= (k % period) == 0;
						default: result_stall <= $urandom_range(0, 99) < 85;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Scoreboard. Outputs are sampled at the rising edge, before this edge's updates,
	// which is what the handshake sees.
	always @(posedge clk) begin : score
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: value %0d status %0d",
					result.value, result.status));
			end else begin
				want = expected_results.pop_front();
				if (result.value !== want.value) begin
					report_mismatch($sformatf("value %0d, expected %0d",
						result.value, want.value));
				end
				if (result.status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %0d",
						result.status, want.status));
				end
			end
		end
	end

	// Watchdog: the run ends if no request and no result is taken for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((frame_valid && !frame_stall) || (result_valid && !result_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("Timeout: no request or result taken for %0d cycles", STALL_LIMIT);
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

`default_nettype wire

>>> humidity_temp_frame_decoder.f
hdl/htfd_pkg.sv
hdl/humidity_temp_frame_decoder.sv
tb/humidity_temp_frame_decoder_tb.sv
